// ----- rtl/core/qrs_pkg.sv -----
// shared constants, arctangent table and helper functions for the
// quadrilateral rectangularity scorer; no dependencies
package qrs_pkg;

  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 7;
  localparam int COORD_W             = 20;
  localparam int DIFF_W              = COORD_W + 1;
  localparam int SCORE_W             = 17;
  localparam int TAB_FRAC            = 16;
  localparam int NUM_CORNERS         = 4;
  localparam int RATIO_W             = 26;
  localparam int RECIP_SH            = 34;
  localparam logic [RATIO_W-1:0] RECIP_M = 26'd47721859;

  typedef struct packed {
    logic valid;
    logic found;
  } ctrl_t;

  function automatic int atan_q16(input int i);
    case (i)
      0:  atan_q16 = 2949120;
      1:  atan_q16 = 1740967;
      2:  atan_q16 = 919879;
      3:  atan_q16 = 466945;
      4:  atan_q16 = 234379;
      5:  atan_q16 = 117304;
      6:  atan_q16 = 58666;
      7:  atan_q16 = 29335;
      8:  atan_q16 = 14668;
      9:  atan_q16 = 7334;
      10: atan_q16 = 3667;
      11: atan_q16 = 1833;
      12: atan_q16 = 917;
      13: atan_q16 = 458;
      14: atan_q16 = 229;
      15: atan_q16 = 115;
      16: atan_q16 = 57;
      17: atan_q16 = 29;
      18: atan_q16 = 14;
      19: atan_q16 = 7;
      20: atan_q16 = 4;
      21: atan_q16 = 2;
      22: atan_q16 = 1;
      default: atan_q16 = 0;
    endcase
  endfunction

  // table entry rounded half up to f fractional bits
  function automatic int tab_angle(input int i, input int f);
    int sh;
    sh = TAB_FRAC - f;
    tab_angle = (atan_q16(i) + (1 << (sh - 1))) >>> sh;
  endfunction

endpackage

// ----- rtl/core/qrs_cordic.sv -----
// pipelined vectoring cordic, atan2 in fixed-point degrees
// depends on qrs_pkg
module qrs_cordic #(
  parameter int N  = qrs_pkg::CORDIC_STAGES_DEF,
  parameter int F  = qrs_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int AW = F + 10
) (
  input  logic                             clk,
  input  logic signed [qrs_pkg::DIFF_W-1:0] num,
  input  logic signed [qrs_pkg::DIFF_W-1:0] den,
  output logic signed [AW-1:0]             angle
);

  localparam int W = qrs_pkg::DIFF_W + N + 3;
  localparam logic signed [AW-1:0] RIGHT = AW'(90 << F);

  logic signed [W-1:0]  x_r [0:N];
  logic signed [W-1:0]  y_r [0:N];
  logic signed [AW-1:0] z_r [0:N];
  logic                 zero_r [0:N];

  logic signed [W-1:0] xi, yi;
  assign xi = W'(den) <<< N;
  assign yi = W'(num) <<< N;

  always_ff @(posedge clk) begin
    zero_r[0] <= (num == '0) && (den == '0);
    if (xi[W-1]) begin
      if (!yi[W-1]) begin
        x_r[0] <= yi;
        y_r[0] <= -xi;
        z_r[0] <= RIGHT;
      end else begin
        x_r[0] <= -yi;
        y_r[0] <= xi;
        z_r[0] <= -RIGHT;
      end
    end else begin
      x_r[0] <= xi;
      y_r[0] <= yi;
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [AW-1:0] TA = AW'(qrs_pkg::tab_angle(i, F));
    logic signed [W-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      zero_r[i+1] <= zero_r[i];
      if (!y_r[i][W-1]) begin
        x_r[i+1] <= x_r[i] + ys;
        y_r[i+1] <= y_r[i] - xs;
        z_r[i+1] <= z_r[i] + TA;
      end else begin
        x_r[i+1] <= x_r[i] - ys;
        y_r[i+1] <= y_r[i] + xs;
        z_r[i+1] <= z_r[i] - TA;
      end
    end
  end

  assign angle = zero_r[N] ? '0 : z_r[N];

endmodule

// ----- rtl/core/qrs_lane.sv -----
// one corner lane: edge differences, two cordics and the 90 degree deviation
// depends on qrs_pkg and qrs_cordic
module qrs_lane #(
  parameter int N = qrs_pkg::CORDIC_STAGES_DEF,
  parameter int F = qrs_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic signed [qrs_pkg::COORD_W-1:0] ax,
  input  logic signed [qrs_pkg::COORD_W-1:0] ay,
  input  logic signed [qrs_pkg::COORD_W-1:0] bx,
  input  logic signed [qrs_pkg::COORD_W-1:0] by,
  input  logic signed [qrs_pkg::COORD_W-1:0] cx,
  input  logic signed [qrs_pkg::COORD_W-1:0] cy,
  output logic [F+6:0]                      dev
);

  localparam int DW = qrs_pkg::DIFF_W;
  localparam int AW = F + 10;
  localparam logic [AW:0] HALF  = (AW+1)'(180 << F);
  localparam logic [AW:0] RIGHT = (AW+1)'(90 << F);

  logic signed [DW-1:0] na_r, da_r, nc_r, dc_r;
  logic signed [AW-1:0] phi_a, phi_c;
  logic signed [AW:0]   d;
  logic [AW:0]          m0, m1, m2, r;
  logic [F+6:0]         dev_r;

  always_ff @(posedge clk) begin
    na_r <= DW'(bx) - DW'(ax);
    da_r <= DW'(by) - DW'(ay);
    nc_r <= DW'(bx) - DW'(cx);
    dc_r <= DW'(by) - DW'(cy);
  end

  qrs_cordic #(.N(N), .F(F), .AW(AW)) u_cordic_a (
    .clk(clk), .num(na_r), .den(da_r), .angle(phi_a)
  );

  qrs_cordic #(.N(N), .F(F), .AW(AW)) u_cordic_c (
    .clk(clk), .num(nc_r), .den(dc_r), .angle(phi_c)
  );

  always_comb begin
    d  = (AW+1)'(phi_c) - (AW+1)'(phi_a);
    m0 = d[AW] ? -d : d;
    m1 = (m0 >= HALF) ? m0 - HALF : m0;
    m2 = (m1 >= HALF) ? m1 - HALF : m1;
    r  = (m2 >= RIGHT) ? m2 - RIGHT : RIGHT - m2;
  end

  always_ff @(posedge clk) begin
    dev_r <= r[F+6:0];
  end

  assign dev = dev_r;

endmodule

// ----- rtl/core/qrs_merge.sv -----
// merges the four corner deviations into the q1.16 score
// depends on qrs_pkg
module qrs_merge #(
  parameter int F = qrs_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  qrs_pkg::ctrl_t                ctrl_in,
  input  logic [F+6:0]                  dev0,
  input  logic [F+6:0]                  dev1,
  input  logic [F+6:0]                  dev2,
  input  logic [F+6:0]                  dev3,
  output logic                          valid,
  output logic [qrs_pkg::SCORE_W-1:0]   score
);

  localparam int RW = qrs_pkg::RATIO_W;
  localparam int SW = F + 9;
  localparam logic [SW-1:0] FULL = SW'(360 << F);

  logic [SW-1:0]   sum, num;
  logic [RW-1:0]   v_r;
  logic [2*RW-1:0] prod_r;
  logic [2*RW-1:0] q;
  qrs_pkg::ctrl_t  c1_r, c2_r;
  logic            valid_r;
  logic [qrs_pkg::SCORE_W-1:0] score_r;

  assign sum = SW'(dev0) + SW'(dev1) + SW'(dev2) + SW'(dev3);
  assign num = FULL - sum;
  assign q   = prod_r >> qrs_pkg::RECIP_SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r    <= '0;
      c2_r    <= '0;
      valid_r <= 1'b0;
    end else begin
      c1_r    <= ctrl_in;
      c2_r    <= c1_r;
      valid_r <= c2_r.valid;
    end
    v_r     <= (RW'(num) << (16 - F)) + RW'(180);
    prod_r  <= (2*RW)'(v_r) * (2*RW)'(qrs_pkg::RECIP_M);
    score_r <= c2_r.found ? q[qrs_pkg::SCORE_W-1:0] : '0;
  end

  assign valid = valid_r;
  assign score = score_r;

endmodule

// ----- rtl/core/quad_rectangularity_score.sv -----
// top level of the quadrilateral rectangularity scorer
// depends on qrs_pkg, qrs_lane, qrs_merge
//
// usage: drive the found flag and four corners (signed q16.4) with start
// high for one cycle; busy is held low, so a request is taken every cycle.
// four corner lanes each run two pipelined cordics (one per edge) in
// parallel, then a merge stage sums the deviations and scales the score.
// a request passes through the lane pipelines and the merge registers to
// out_valid; throughput one request per cycle.
// out_valid pulses for one cycle with out_score; the receiver cannot stall
// and needs no back pressure. found low gives a score of 0.
// reset (rst_n low, synchronous) clears the request valid pipeline only;
// in-flight requests are dropped and no result is produced for them.
module quad_rectangularity_score #(
  parameter int CORDIC_STAGES   = qrs_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = qrs_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_found,
  input  logic signed [qrs_pkg::COORD_W-1:0] in_corner0_x,
  input  logic signed [qrs_pkg::COORD_W-1:0] in_corner0_y,
  input  logic signed [qrs_pkg::COORD_W-1:0] in_corner1_x,
  input  logic signed [qrs_pkg::COORD_W-1:0] in_corner1_y,
  input  logic signed [qrs_pkg::COORD_W-1:0] in_corner2_x,
  input  logic signed [qrs_pkg::COORD_W-1:0] in_corner2_y,
  input  logic signed [qrs_pkg::COORD_W-1:0] in_corner3_x,
  input  logic signed [qrs_pkg::COORD_W-1:0] in_corner3_y,
  output logic                              out_valid,
  output logic [qrs_pkg::SCORE_W-1:0]       out_score
);

  localparam int F       = ANGLE_FRAC_BITS;
  localparam int NC      = qrs_pkg::NUM_CORNERS;
  localparam int LANE_LAT = CORDIC_STAGES + 3;

  logic signed [qrs_pkg::COORD_W-1:0] px [0:NC-1];
  logic signed [qrs_pkg::COORD_W-1:0] py [0:NC-1];
  logic [F+6:0]   dev [0:NC-1];
  qrs_pkg::ctrl_t ctrl_r [0:LANE_LAT-1];
  qrs_pkg::ctrl_t ctrl_nxt;

  assign busy = 1'b0;

  assign px[0] = in_corner0_x;
  assign py[0] = in_corner0_y;
  assign px[1] = in_corner1_x;
  assign py[1] = in_corner1_y;
  assign px[2] = in_corner2_x;
  assign py[2] = in_corner2_y;
  assign px[3] = in_corner3_x;
  assign py[3] = in_corner3_y;

  assign ctrl_nxt.valid = start & ~busy;
  assign ctrl_nxt.found = in_found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) ctrl_r[i] <= '0;
    end else begin
      ctrl_r[0] <= ctrl_nxt;
      for (int i = 1; i < LANE_LAT; i++) ctrl_r[i] <= ctrl_r[i-1];
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_lane
    qrs_lane #(.N(CORDIC_STAGES), .F(F)) u_lane (
      .clk (clk),
      .ax  (px[(k+NC-1)%NC]),
      .ay  (py[(k+NC-1)%NC]),
      .bx  (px[k]),
      .by  (py[k]),
      .cx  (px[(k+1)%NC]),
      .cy  (py[(k+1)%NC]),
      .dev (dev[k])
    );
  end

  qrs_merge #(.F(F)) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl_in (ctrl_r[LANE_LAT-1]),
    .dev0    (dev[0]),
    .dev1    (dev[1]),
    .dev2    (dev[2]),
    .dev3    (dev[3]),
    .valid   (out_valid),
    .score   (out_score)
  );

endmodule
